[hdl/lpd_pkg.sv]
package lpd_pkg;

  // Framing bytes on the sensor link.
  localparam logic [7:0] SYNC_INFO = 8'hAA;
  localparam logic [7:0] SYNC_MEAS = 8'hFA;
  localparam logic [7:0] ESC_BYTE  = 8'hA9;

  // Second byte of an escape pair.
  localparam logic [7:0] ESC_CODE_A9 = 8'h00;
  localparam logic [7:0] ESC_CODE_AA = 8'h01;

  localparam int unsigned IDX_W = 7;

  // Byte offsets inside the frames. The sync byte is offset 0.
  localparam logic [IDX_W-1:0] INFO_SUM_LAST  = 7'd82;
  localparam logic [IDX_W-1:0] INFO_LAST_IDX  = 7'd84;
  localparam logic [IDX_W-1:0] MEAS_SPEED_IDX = 7'd3;
  localparam logic [IDX_W-1:0] MEAS_SUM_LAST  = 7'd19;
  localparam logic [IDX_W-1:0] MEAS_LAST_IDX  = 7'd21;

  // Ten shifted words of 16 bits stay below 2^26.
  localparam int unsigned ACC_W  = 26;
  localparam int unsigned FOLD_W = 15;

  typedef enum logic [2:0] {
    ST_PENDING   = 3'd0,
    ST_INFO_OK   = 3'd1,
    ST_INFO_BAD  = 3'd2,
    ST_MEAS_OK   = 3'd3,
    ST_MEAS_BAD  = 3'd4
  } lpd_status_e;

  typedef enum logic [1:0] {
    OP_NONE = 2'd0,
    OP_INFO = 2'd1,
    OP_MEAS = 2'd2
  } lpd_op_e;

  // One classified byte handed from the framer to the checksum unit.
  typedef struct packed {
    lpd_op_e          kind;
    logic [7:0]       data;
    logic [IDX_W-1:0] idx;
  } lpd_op_t;

endpackage

[hdl/lpd_if.sv]
interface lpd_byte_if;
  logic       valid;
  logic       ready;
  logic [7:0] rx_byte;

  modport source (output valid, output rx_byte, input ready);
  modport sink   (input valid, input rx_byte, output ready);
endinterface

interface lpd_result_if;
  logic        valid;
  logic        ready;
  logic [2:0]  status;
  logic [15:0] computed_sum;
  logic [15:0] received_sum;
  logic [15:0] speed_raw;

  modport source (output valid, output status, output computed_sum,
                  output received_sum, output speed_raw, input ready);
  modport sink   (input valid, input status, input computed_sum,
                  input received_sum, input speed_raw, output ready);
endinterface

[hdl/lidar_packet_deframer.sv]
// Channel  Dir  Payload                                          Handshake
// rx_i     in   rx_byte[7:0]                                     valid / ready
// res_o    out  status[2:0], computed_sum, received_sum,         valid / ready
//               speed_raw (16 bits each)
//
// One byte is taken per cycle while the queue is not full, and every byte
// gives exactly one result. A result is offered once its request has been
// popped from the queue and has landed in the output register.
// Reset is asynchronous and active low; it returns the framer to idle and
// empties the queue. There is no clearing pass.
// A stalled result side fills the queue; rx_i.ready drops only when it is full.
module lidar_packet_deframer import lpd_pkg::*; #(
  parameter int unsigned QUEUE_DEPTH = 2
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  lpd_byte_if.sink       rx_i,
  lpd_result_if.source   res_o
);

  // The framer in front tracks sync, escape decoding and the byte offset,
  // and turns every received byte into a request: a decoded frame byte with
  // its offset, or an empty request for ignored, escape and aborting bytes.
  // The checksum unit behind the queue builds the little-endian words,
  // runs the checksums, and produces one result per request.

  lpd_op_t front_op;
  lpd_op_t back_op;
  logic    front_push;
  logic    queue_full;
  logic    queue_valid;
  logic    back_pop;

  lpd_front u_front (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .valid_i   (rx_i.valid),
    .rx_byte_i (rx_i.rx_byte),
    .ready_o   (rx_i.ready),
    .full_i    (queue_full),
    .push_o    (front_push),
    .op_o      (front_op)
  );

  // The queue lets the framer keep taking bytes while a result waits.
  lpd_fifo #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (front_push),
    .op_i    (front_op),
    .full_o  (queue_full),
    .pop_i   (back_pop),
    .valid_o (queue_valid),
    .op_o    (back_op)
  );

  // The checksum unit pops a request whenever its output register is free
  // or being emptied in the same cycle.
  lpd_back u_back (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .valid_i        (queue_valid),
    .op_i           (back_op),
    .pop_o          (back_pop),
    .res_valid_o    (res_o.valid),
    .res_ready_i    (res_o.ready),
    .status_o       (res_o.status),
    .computed_sum_o (res_o.computed_sum),
    .received_sum_o (res_o.received_sum),
    .speed_raw_o    (res_o.speed_raw)
  );

endmodule

[hdl/lpd_front.sv]
module lpd_front import lpd_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       valid_i,
  input  logic [7:0] rx_byte_i,
  output logic       ready_o,
  input  logic       full_i,
  output logic       push_o,
  output lpd_op_t    op_o
);

  localparam logic [1:0] PH_IDLE = 2'd0;
  localparam logic [1:0] PH_INFO = 2'd1;
  localparam logic [1:0] PH_ESC  = 2'd2;
  localparam logic [1:0] PH_MEAS = 2'd3;

  logic [1:0]       phase_q, phase_d;
  logic [IDX_W-1:0] idx_q, idx_d;
  logic             accept;
  logic             adv;

  assign ready_o = !full_i;
  assign accept  = valid_i && !full_i;
  assign push_o  = accept;

  always_comb begin
    phase_d     = phase_q;
    idx_d       = idx_q;
    adv         = 1'b0;
    op_o.kind   = OP_NONE;
    op_o.data   = rx_byte_i;
    op_o.idx    = idx_q;
    case (phase_q)
      PH_IDLE: begin
        if (rx_byte_i == SYNC_INFO) begin
          phase_d   = PH_INFO;
          op_o.kind = OP_INFO;
          op_o.idx  = '0;
          idx_d     = IDX_W'(1);
        end else if (rx_byte_i == SYNC_MEAS) begin
          phase_d   = PH_MEAS;
          op_o.kind = OP_MEAS;
          op_o.idx  = '0;
          idx_d     = IDX_W'(1);
        end
      end
      PH_INFO: begin
        // A bare info sync byte drops the frame and is not taken as a new sync.
        if (rx_byte_i == SYNC_INFO) begin
          phase_d = PH_IDLE;
        end else if (rx_byte_i == ESC_BYTE) begin
          phase_d = PH_ESC;
        end else begin
          op_o.kind = OP_INFO;
          adv       = 1'b1;
        end
      end
      PH_ESC: begin
        if (rx_byte_i == ESC_CODE_A9) begin
          op_o.kind = OP_INFO;
          op_o.data = ESC_BYTE;
          phase_d   = PH_INFO;
          adv       = 1'b1;
        end else if (rx_byte_i == ESC_CODE_AA) begin
          op_o.kind = OP_INFO;
          op_o.data = SYNC_INFO;
          phase_d   = PH_INFO;
          adv       = 1'b1;
        end else begin
          phase_d = PH_IDLE;
        end
      end
      PH_MEAS: begin
        op_o.kind = OP_MEAS;
        adv       = 1'b1;
      end
      default: begin
        phase_d = PH_IDLE;
      end
    endcase

    if (adv) begin
      idx_d = idx_q + IDX_W'(1);
      if ((op_o.kind == OP_INFO && idx_q == INFO_LAST_IDX) ||
          (op_o.kind == OP_MEAS && idx_q == MEAS_LAST_IDX)) begin
        phase_d = PH_IDLE;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PH_IDLE;
      idx_q   <= '0;
    end else if (accept) begin
      phase_q <= phase_d;
      idx_q   <= idx_d;
    end
  end

  a_sync_opens_info: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept && phase_q == PH_IDLE && rx_byte_i == SYNC_INFO |=> phase_q == PH_INFO)
    else $error("info sync byte did not open a frame");

endmodule

[hdl/lpd_fifo.sv]
module lpd_fifo import lpd_pkg::*; #(
  parameter int unsigned DEPTH = 2
) (
  input  logic    clk_i,
  input  logic    rst_ni,
  input  logic    push_i,
  input  lpd_op_t op_i,
  output logic    full_o,
  input  logic    pop_i,
  output logic    valid_o,
  output lpd_op_t op_o
);

  localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CNT_W = $clog2(DEPTH + 1);
  localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);
  localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(DEPTH);

  lpd_op_t          mem_q [DEPTH];
  logic [PTR_W-1:0] wr_ptr_q, rd_ptr_q;
  logic [CNT_W-1:0] cnt_q;
  logic             do_push, do_pop;

  assign full_o  = (cnt_q == CNT_FULL);
  assign valid_o = (cnt_q != '0);
  assign op_o    = mem_q[rd_ptr_q];
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && valid_o;

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= op_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_q <= (wr_ptr_q == PTR_LAST) ? '0 : wr_ptr_q + PTR_W'(1);
      end
      if (do_pop) begin
        rd_ptr_q <= (rd_ptr_q == PTR_LAST) ? '0 : rd_ptr_q + PTR_W'(1);
      end
      if (do_push && !do_pop) begin
        cnt_q <= cnt_q + CNT_W'(1);
      end else if (do_pop && !do_push) begin
        cnt_q <= cnt_q - CNT_W'(1);
      end
    end
  end

  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= CNT_FULL)
    else $error("queue count past its depth");

endmodule

[hdl/lpd_back.sv]
module lpd_back import lpd_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        valid_i,
  input  lpd_op_t     op_i,
  output logic        pop_o,
  output logic        res_valid_o,
  input  logic        res_ready_i,
  output logic [2:0]  status_o,
  output logic [15:0] computed_sum_o,
  output logic [15:0] received_sum_o,
  output logic [15:0] speed_raw_o
);

  logic [7:0]       hold_q, hold_d;
  logic [ACC_W-1:0] acc_q, acc_d;
  logic [15:0]      speed_q, speed_d;
  logic             out_valid_q;
  lpd_status_e      status_q, status_d;
  logic [15:0]      comp_q, comp_d;
  logic [15:0]      rcv_q, rcv_d;
  logic [15:0]      spd_q, spd_d;
  logic [15:0]      word;
  logic [15:0]      info_sum;
  logic [ACC_W-1:0] fold_full;
  logic [FOLD_W-1:0] fold;

  assign pop_o     = valid_i && (!out_valid_q || res_ready_i);
  assign word      = {op_i.data, hold_q};
  assign info_sum  = acc_q[15:0] + word;
  assign fold_full = acc_q + (acc_q >> FOLD_W);
  assign fold      = fold_full[FOLD_W-1:0];

  always_comb begin
    hold_d   = hold_q;
    acc_d    = acc_q;
    speed_d  = speed_q;
    status_d = ST_PENDING;
    comp_d   = '0;
    rcv_d    = '0;
    spd_d    = '0;
    case (op_i.kind)
      OP_INFO: begin
        if (op_i.idx == '0) begin
          hold_d = op_i.data;
          acc_d  = '0;
        end else if (op_i.idx[0]) begin
          hold_d = op_i.data;
        end else if (op_i.idx <= INFO_SUM_LAST) begin
          acc_d = ACC_W'(info_sum);
        end else if (op_i.idx == INFO_LAST_IDX) begin
          status_d = (acc_q[15:0] == word) ? ST_INFO_OK : ST_INFO_BAD;
          comp_d   = acc_q[15:0];
          rcv_d    = word;
        end
      end
      OP_MEAS: begin
        if (op_i.idx == '0) begin
          hold_d = op_i.data;
          acc_d  = '0;
        end else if (!op_i.idx[0]) begin
          hold_d = op_i.data;
        end else begin
          if (op_i.idx <= MEAS_SUM_LAST) begin
            acc_d = {acc_q[ACC_W-2:0], 1'b0} + ACC_W'(word);
          end
          if (op_i.idx == MEAS_SPEED_IDX) begin
            speed_d = word;
          end
          if (op_i.idx == MEAS_LAST_IDX) begin
            acc_d    = ACC_W'(fold);
            status_d = (16'(fold) == word) ? ST_MEAS_OK : ST_MEAS_BAD;
            comp_d   = 16'(fold);
            rcv_d    = word;
            spd_d    = speed_q;
          end
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hold_q      <= '0;
      acc_q       <= '0;
      speed_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (pop_o) begin
        hold_q      <= hold_d;
        acc_q       <= acc_d;
        speed_q     <= speed_d;
        out_valid_q <= 1'b1;
      end else if (res_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (pop_o) begin
      status_q <= status_d;
      comp_q   <= comp_d;
      rcv_q    <= rcv_d;
      spd_q    <= spd_d;
    end
  end

  assign res_valid_o    = out_valid_q;
  assign status_o       = status_q;
  assign computed_sum_o = comp_q;
  assign received_sum_o = rcv_q;
  assign speed_raw_o    = spd_q;

  a_pending_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && status_q == ST_PENDING |->
      comp_q == '0 && rcv_q == '0 && spd_q == '0)
    else $error("pending result carries nonzero fields");

  a_info_no_speed: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && (status_q == ST_INFO_OK || status_q == ST_INFO_BAD) |->
      spd_q == '0)
    else $error("info result carries a speed word");

endmodule
